FILE: sv/battery_low_voltage_step_down_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the low-voltage step-down block
// Concurrent checks that compile to nothing when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BATTERY_LOW_VOLTAGE_STEP_DOWN_ASSERT_SVH
`define BATTERY_LOW_VOLTAGE_STEP_DOWN_ASSERT_SVH

`ifndef SYNTHESIS

// The expression must hold at every clock edge outside reset.
`define BLVSD_ASSERT_ALWAYS(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) \
      else $error("assertion failed: invariant");

// When the antecedent holds, the consequent must hold at the same edge.
`define BLVSD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: implication");

`else

`define BLVSD_ASSERT_ALWAYS(label, clk, rst, expr)
`define BLVSD_ASSERT_IMPLIES(label, clk, rst, ante, cons)

`endif

`endif

FILE: sv/blvsd_pkg.sv
// ----------------------------------------------------------------------------
// Low-voltage step-down package
// Shared types, register map and reset values.
// ----------------------------------------------------------------------------
package blvsd_pkg;

   // Item kinds carried on req_tuser.
   localparam logic FUNC_BEGIN  = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // Flash requests.
   localparam logic [3:0] FLASH_NONE     = 4'd0;
   localparam logic [3:0] FLASH_STEP     = 4'd3;
   localparam logic [3:0] FLASH_CRITICAL = 4'd10;

   localparam logic [3:0] LOW_RUN_MAX = 4'd15;

   typedef enum logic [1:0] {
      PHASE_NORMAL = 2'd0,
      PHASE_WAIT   = 2'd1,
      PHASE_OFF    = 2'd2
   } phase_type;

   typedef enum logic [2:0] {
      REG_LOW_THRESHOLD      = 3'd0,
      REG_CRITICAL_THRESHOLD = 3'd1,
      REG_TRIGGER_COUNT      = 3'd2,
      REG_LEVEL_MOON         = 3'd3,
      REG_LEVEL_LOW          = 3'd4,
      REG_LEVEL_HIGH         = 3'd5,
      REG_MODE_COUNT         = 3'd6,
      REG_FAST_ABOVE         = 3'd7
   } reg_index_type;

   typedef struct packed {
      logic [7:0] low_threshold;
      logic [7:0] critical_threshold;
      logic [3:0] trigger_count;
      logic [7:0] level_moon;
      logic [7:0] level_low;
      logic [7:0] level_high;
      logic [1:0] mode_count;
      logic [7:0] fast_above;
   } cfg_type;

   localparam cfg_type CFG_RESET = '{
      low_threshold:      8'd130,
      critical_threshold: 8'd120,
      trigger_count:      4'd8,
      level_moon:         8'd3,
      level_low:          8'd14,
      level_high:         8'd255,
      mode_count:         2'd3,
      fast_above:         8'd8
   };

   typedef struct packed {
      phase_type  phase;
      logic [3:0] low_run;
      logic [7:0] level;
      logic [1:0] mode_index;
   } state_type;

   localparam state_type STATE_RESET = '{
      phase:      PHASE_OFF,
      low_run:    4'd0,
      level:      8'd0,
      mode_index: 2'd0
   };

   typedef struct packed {
      logic       func;
      logic [7:0] sample;
      logic [1:0] start_mode;
   } item_type;

   typedef struct packed {
      logic [1:0] phase_now;
      logic [1:0] mode_now;
      logic [7:0] flash_level;
      logic [3:0] flash_count;
      logic       fast_pwm;
      logic [7:0] duty_level;
   } result_type;

endpackage

FILE: sv/blvsd_step.sv
// ----------------------------------------------------------------------------
// Step-down decision logic
// Computes the next controller state and the result for one item.
// ----------------------------------------------------------------------------
module blvsd_step
   import blvsd_pkg::*;
(
   input  cfg_type    cfg,
   input  state_type  state_cur,
   input  item_type   item,
   output state_type  state_nxt,
   output result_type result
);

   function automatic logic [7:0] mode_level(input cfg_type c, input logic [1:0] idx);
      logic [7:0] lvl;
      case (idx)
         2'd0:    lvl = c.level_moon;
         2'd1:    lvl = c.level_low;
         default: lvl = c.level_high;
      endcase
      return lvl;
   endfunction

   logic [7:0] threshold;
   logic       below;
   logic [3:0] run_inc;
   logic       trigger;
   logic [3:0] run_nxt;
   logic [1:0] mode_top;
   logic [1:0] begin_mode;
   logic [7:0] half;
   logic [7:0] step_level;
   logic [1:0] step_mode;
   logic [3:0] flashes;
   logic [7:0] flash_lvl;

   always_comb begin
      threshold = (state_cur.phase == PHASE_WAIT) ? cfg.critical_threshold
                                                  : cfg.low_threshold;
      below     = item.sample < threshold;
      run_inc   = (state_cur.low_run == LOW_RUN_MAX) ? LOW_RUN_MAX
                                                     : state_cur.low_run + 4'd1;
      trigger   = below && (run_inc > cfg.trigger_count);
      run_nxt   = (below && !trigger) ? run_inc : 4'd0;

      // A mode count of zero behaves like one.
      mode_top   = (cfg.mode_count == 2'd0) ? 2'd0 : cfg.mode_count - 2'd1;
      begin_mode = (item.start_mode > mode_top) ? mode_top : item.start_mode;

      // Halve the level, floored at moon, then drop the mode once if the
      // new level sits below the level of the current mode.
      half = state_cur.level >> 1;
      if (half < cfg.level_moon) begin
         step_level = cfg.level_moon;
         step_mode  = 2'd0;
      end else begin
         step_level = half;
         step_mode  = state_cur.mode_index;
      end
      if (step_mode != 2'd0 && step_level < mode_level(cfg, step_mode)) begin
         step_mode = step_mode - 2'd1;
      end

      state_nxt = state_cur;
      flashes   = FLASH_NONE;
      flash_lvl = 8'd0;

      if (item.func == FUNC_BEGIN) begin
         state_nxt.mode_index = begin_mode;
         state_nxt.level      = mode_level(cfg, begin_mode);
         state_nxt.phase      = PHASE_NORMAL;
         state_nxt.low_run    = 4'd0;
      end else begin
         unique case (state_cur.phase)
            PHASE_NORMAL: begin
               state_nxt.low_run = run_nxt;
               if (trigger) begin
                  if (state_cur.mode_index == 2'd0 &&
                      state_cur.level <= cfg.level_moon) begin
                     state_nxt.phase = PHASE_WAIT;
                  end else begin
                     flashes              = FLASH_STEP;
                     flash_lvl            = state_cur.level;
                     state_nxt.level      = step_level;
                     state_nxt.mode_index = step_mode;
                  end
               end
            end
            PHASE_WAIT: begin
               state_nxt.low_run = run_nxt;
               if (trigger) begin
                  flashes         = FLASH_CRITICAL;
                  flash_lvl       = state_cur.level;
                  state_nxt.level = 8'd0;
                  state_nxt.phase = PHASE_OFF;
               end
            end
            default: begin
               // Shut off: samples leave the state alone.
            end
         endcase
      end

      result.duty_level  = state_nxt.level;
      result.fast_pwm    = state_nxt.level > cfg.fast_above;
      result.flash_count = flashes;
      result.flash_level = flash_lvl;
      result.mode_now    = state_nxt.mode_index;
      result.phase_now   = state_nxt.phase;
   end

endmodule

FILE: sv/battery_low_voltage_step_down.sv
// ----------------------------------------------------------------------------
// Battery low-voltage step-down controller
// Tracks battery samples and steps the light level down as the cell sags.
// ----------------------------------------------------------------------------
// Usage: each transaction on the req_ channel is either a begin item
// (req_tuser = 0), which selects a start mode and loads its level, or a
// battery sample (req_tuser = 1). Every input transaction produces exactly
// one result transaction on the rsp_ channel carrying the current level,
// the fast PWM select, any warning flash request, the mode and the phase.
// The item passes an input register, the decision logic and a result
// register, and rsp_tvalid rises once the result register holds it.
// One item is accepted every cycle while the receiver takes every result;
// the state registers update as each item moves from the input register
// into the result register. When the receiver stalls, the result register
// holds its transaction and the input register still takes one more item
// if it is empty; after that req_tready falls until the result is taken.
// Reset empties both registers, loads the register defaults and leaves the
// controller shut off at level zero until a begin item arrives.
// The user must write registers over the csr_ port only while no
// transaction is in flight; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module battery_low_voltage_step_down
   import blvsd_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [7:0] sample, [9:8] start_mode, rest zero
   input  logic        req_tuser,   // [0] func

   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // [7:0] duty_level, [8] fast_pwm, [12:9] flash_count, [20:13] flash_level,
   // [22:21] mode_now, [24:23] phase_now, rest zero
   output logic [31:0] rsp_tdata,

   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [4:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   `include "battery_low_voltage_step_down_assert.svh"

   // Configuration registers.
   cfg_type       cfg_ff;
   cfg_type       cfg_in;
   reg_index_type csr_index;
   logic          csr_write;

   // Controller state.
   state_type     state_ff;
   state_type     state_in;

   // Input register stage.
   logic          item_valid_ff;
   item_type      item_ff;
   item_type      item_in;

   // Result register stage.
   logic          rsp_valid_ff;
   result_type    rsp_data_ff;
   result_type    step_result;

   logic          rsp_load;
   logic          item_advance;
   logic          req_accept;

   assign csr_pready = 1'b1;
   assign csr_index  = reg_index_type'(csr_paddr[4:2]);
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            REG_LOW_THRESHOLD:      cfg_in.low_threshold      = csr_pwdata[7:0];
            REG_CRITICAL_THRESHOLD: cfg_in.critical_threshold = csr_pwdata[7:0];
            REG_TRIGGER_COUNT:      cfg_in.trigger_count      = csr_pwdata[3:0];
            REG_LEVEL_MOON:         cfg_in.level_moon         = csr_pwdata[7:0];
            REG_LEVEL_LOW:          cfg_in.level_low          = csr_pwdata[7:0];
            REG_LEVEL_HIGH:         cfg_in.level_high         = csr_pwdata[7:0];
            REG_MODE_COUNT:         cfg_in.mode_count         = csr_pwdata[1:0];
            REG_FAST_ABOVE:         cfg_in.fast_above         = csr_pwdata[7:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_LOW_THRESHOLD:      csr_prdata = {24'd0, cfg_ff.low_threshold};
         REG_CRITICAL_THRESHOLD: csr_prdata = {24'd0, cfg_ff.critical_threshold};
         REG_TRIGGER_COUNT:      csr_prdata = {28'd0, cfg_ff.trigger_count};
         REG_LEVEL_MOON:         csr_prdata = {24'd0, cfg_ff.level_moon};
         REG_LEVEL_LOW:          csr_prdata = {24'd0, cfg_ff.level_low};
         REG_LEVEL_HIGH:         csr_prdata = {24'd0, cfg_ff.level_high};
         REG_MODE_COUNT:         csr_prdata = {30'd0, cfg_ff.mode_count};
         REG_FAST_ABOVE:         csr_prdata = {24'd0, cfg_ff.fast_above};
         default:                csr_prdata = 32'd0;
      endcase
   end

   // The result register loads whenever it is empty or being drained; the
   // item in the input register moves on in that same cycle, and the input
   // register is free for a new transaction when it is empty or moving on.
   assign rsp_load     = !rsp_valid_ff || rsp_tready;
   assign item_advance = item_valid_ff && rsp_load;
   assign req_tready   = !item_valid_ff || rsp_load;
   assign req_accept   = req_tvalid && req_tready;

   assign item_in.func       = req_tuser;
   assign item_in.sample     = req_tdata[7:0];
   assign item_in.start_mode = req_tdata[9:8];

   blvsd_step u_step (
      .cfg       (cfg_ff),
      .state_cur (state_ff),
      .item      (item_ff),
      .state_nxt (state_in),
      .result    (step_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff        <= CFG_RESET;
         state_ff      <= STATE_RESET;
         item_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cfg_ff <= cfg_in;
         if (item_advance) begin
            state_ff <= state_in;
         end
         if (req_accept) begin
            item_valid_ff <= 1'b1;
         end else if (item_advance) begin
            item_valid_ff <= 1'b0;
         end
         if (rsp_load) begin
            rsp_valid_ff <= item_valid_ff;
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         item_ff <= item_in;
      end
      if (item_advance) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {7'd0, rsp_data_ff};

   // A shut-off controller always sits at level zero.
   `BLVSD_ASSERT_ALWAYS(a_off_level_zero, clock, reset,
      (state_ff.phase != PHASE_OFF) || (state_ff.level == 8'd0))

   // Mode index three never arises.
   `BLVSD_ASSERT_ALWAYS(a_mode_in_range, clock, reset, state_ff.mode_index != 2'd3)

   // A critical flash request always comes with the light shut off.
   `BLVSD_ASSERT_IMPLIES(a_critical_shuts_off, clock, reset,
      rsp_valid_ff && (rsp_data_ff.flash_count == FLASH_CRITICAL),
      (rsp_data_ff.phase_now == PHASE_OFF) && (rsp_data_ff.duty_level == 8'd0))

   // No flash request means no flash level.
   `BLVSD_ASSERT_IMPLIES(a_no_flash_no_level, clock, reset,
      rsp_valid_ff && (rsp_data_ff.flash_count == FLASH_NONE),
      rsp_data_ff.flash_level == 8'd0)

endmodule
